/* src/asad_pkg.sv */
// ============================================================================
// asad_pkg: shared types and constants for the step and activity detector
// Holds field widths, register indexes, reset values, activity codes and the
// command bundle that the controller drives into the datapath.
// ============================================================================
`default_nettype none

package asad_pkg;

    // Field widths
    localparam int AXIS_W  = 16;
    localparam int TIME_W  = 32;
    localparam int LEVEL_W = 16;
    localparam int COUNT_W = 32;
    localparam int ACT_W   = 2;
    localparam int SUM_W   = 32;   // 3 * 2^30 fits in 32 bits
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Square root unit: one result bit per step
    localparam int ROOT_STEPS = LEVEL_W;
    localparam int CNT_W      = $clog2(ROOT_STEPS);
    localparam int REM_W      = LEVEL_W + 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ONE_G      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATIONARY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WALKING    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UPLOAD     = 3'd6;

    // Register reset values (LSB units, 16384 LSB = 1 g; times in ms)
    localparam logic [CFG_DATA_W-1:0] RST_ONE_G      = 16'd16384;
    localparam logic [CFG_DATA_W-1:0] RST_STATIONARY = 16'd819;
    localparam logic [CFG_DATA_W-1:0] RST_WALKING    = 16'd4096;
    localparam logic [CFG_DATA_W-1:0] RST_STEP_TH    = 16'd2458;
    localparam logic [CFG_DATA_W-1:0] RST_RELEASE_TH = 16'd1229;
    localparam logic [CFG_DATA_W-1:0] RST_MIN_GAP    = 16'd200;
    localparam logic [CFG_DATA_W-1:0] RST_UPLOAD     = 16'd1000;

    // Activity classes
    localparam logic [ACT_W-1:0] ACT_STATIONARY = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WALKING    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RUNNING    = 2'd2;

    // Axis select for the shared squaring multiplier
    localparam logic [1:0] AXIS_SEL_X = 2'd0;
    localparam logic [1:0] AXIS_SEL_Y = 2'd1;
    localparam logic [1:0] AXIS_SEL_Z = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;        // capture the input transaction
        logic       mul_en;      // square the selected axis
        logic [1:0] mul_sel;
        logic       acc_en;      // add the last square into the sum
        logic       root_start;  // load the square root unit
        logic       root_step;   // one bit of the square root
        logic       mot_en;      // register the motion level
        logic       dec_en;      // update step state, load the result
    } cmd_t;

endpackage

`default_nettype wire

/* src/asad_ctrl.sv */
// ============================================================================
// asad_ctrl: sequencing controller
// Steps one sample through squaring, square root, motion and decision, and
// owns the handshake flags of both channels.
// ============================================================================
`default_nettype none

module asad_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output asad_pkg::cmd_t      cmd
);
    import asad_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_ROOT = 3'd2;
    localparam logic [2:0] ST_MOT  = 3'd3;
    localparam logic [2:0] ST_DEC  = 3'd4;

    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(3);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQ;
                    cnt_next   = '0;
                end
            end
            ST_SQ:
            begin
                // square x, y, z in turn; add each product into the sum in the following cycle
                cmd.mul_en  = (cnt_reg != SQ_LAST);
                cmd.mul_sel = cnt_reg[1:0];
                cmd.acc_en  = (cnt_reg != '0);
                if (cnt_reg == SQ_LAST)
                begin
                    cmd.root_start = 1'b1;
                    state_next     = ST_ROOT;
                    cnt_next       = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == ROOT_LAST)
                begin
                    state_next = ST_MOT;
                end
            end
            ST_MOT:
            begin
                cmd.mot_en = 1'b1;
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.dec_en     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // A new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dec_en |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending result");

    // An accepted transaction starts the squaring phase from its first axis
    a_accept_to_sq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_SQ && cnt_reg == '0))
        else $error("accepted transaction did not start squaring");

    // The square root runs its full count before the motion stage
    a_root_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT && cnt_reg == ROOT_LAST) |=> (state_reg == ST_MOT))
        else $error("square root phase ended early or late");

    // Pipeline phases never overlap
    a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul_en, cmd.root_step, cmd.mot_en, cmd.dec_en}))
        else $error("overlapping datapath commands");

    // No input is taken while a sample is in flight
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.root_step || cmd.mot_en) |-> !in_ready)
        else $error("input ready while a sample is in flight");

endmodule

`default_nettype wire

/* src/asad_dp.sv */
// ============================================================================
// asad_dp: datapath
// Configuration registers, shared squaring multiplier, bit-serial square
// root, motion classification, step and upload state and the result register.
// ============================================================================
`default_nettype none

module asad_dp (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire asad_pkg::cmd_t                            cmd,
    input  wire logic                                      cfg_we,
    input  wire logic [asad_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  wire logic [asad_pkg::CFG_DATA_W-1:0]           cfg_data,
    input  wire logic signed [asad_pkg::AXIS_W-1:0]        accel_x,
    input  wire logic signed [asad_pkg::AXIS_W-1:0]        accel_y,
    input  wire logic signed [asad_pkg::AXIS_W-1:0]        accel_z,
    input  wire logic [asad_pkg::TIME_W-1:0]               time_ms,
    output logic [asad_pkg::LEVEL_W-1:0]                   motion_level,
    output logic [asad_pkg::ACT_W-1:0]                     activity,
    output logic [asad_pkg::COUNT_W-1:0]                   step_total,
    output logic                                           step_seen,
    output logic                                           upload_due
);
    import asad_pkg::*;

    // Configuration
    logic [CFG_DATA_W-1:0] one_g_reg, stat_lim_reg, walk_lim_reg;
    logic [CFG_DATA_W-1:0] step_th_reg, rel_th_reg, min_gap_reg, upload_per_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_g_reg      <= RST_ONE_G;
            stat_lim_reg   <= RST_STATIONARY;
            walk_lim_reg   <= RST_WALKING;
            step_th_reg    <= RST_STEP_TH;
            rel_th_reg     <= RST_RELEASE_TH;
            min_gap_reg    <= RST_MIN_GAP;
            upload_per_reg <= RST_UPLOAD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ONE_G:      one_g_reg      <= cfg_data;
                REG_STATIONARY: stat_lim_reg   <= cfg_data;
                REG_WALKING:    walk_lim_reg   <= cfg_data;
                REG_STEP_TH:    step_th_reg    <= cfg_data;
                REG_RELEASE_TH: rel_th_reg     <= cfg_data;
                REG_MIN_GAP:    min_gap_reg    <= cfg_data;
                REG_UPLOAD:     upload_per_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Input capture
    logic signed [AXIS_W-1:0] ax_reg, ay_reg, az_reg;
    logic [TIME_W-1:0]        now_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg  <= accel_x;
            ay_reg  <= accel_y;
            az_reg  <= accel_z;
            now_reg <= time_ms;
        end
    end

    // Sum of squares through one multiplier
    logic signed [AXIS_W-1:0]   mul_op;
    logic signed [2*AXIS_W-1:0] mul_sq;
    logic [SUM_W-1:0]           prod_reg, sum_reg, sum_next;

    always_comb
    begin
        case (cmd.mul_sel)
            AXIS_SEL_X: mul_op = ax_reg;
            AXIS_SEL_Y: mul_op = ay_reg;
            AXIS_SEL_Z: mul_op = az_reg;
            default:    mul_op = ax_reg;
        endcase
    end

    assign mul_sq   = mul_op * mul_op;
    assign sum_next = sum_reg + prod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= SUM_W'(unsigned'(mul_sq));
        end
        if (cmd.load)
        begin
            sum_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            sum_reg <= sum_next;
        end
    end

    // Restoring square root, two radicand bits per step
    logic [SUM_W-1:0]   rad_reg;
    logic [REM_W-1:0]   rem_reg, rem_shift, rem_next;
    logic [LEVEL_W-1:0] root_reg;
    logic [REM_W:0]     trial;
    logic               trial_ok;

    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[SUM_W-1:SUM_W-2]};
    assign trial     = {1'b0, rem_shift} - (REM_W + 1)'({root_reg, 2'b01});
    assign trial_ok  = !trial[REM_W];
    assign rem_next  = trial_ok ? trial[REM_W-1:0] : rem_shift;

    always_ff @(posedge clk)
    begin
        if (cmd.root_start)
        begin
            rad_reg  <= sum_next;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[SUM_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= {root_reg[LEVEL_W-2:0], trial_ok};
        end
    end

    // Motion = |magnitude - one g|
    logic [LEVEL_W-1:0] motion_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mot_en)
        begin
            motion_reg <= (root_reg >= one_g_reg) ? (root_reg - one_g_reg)
                                                  : (one_g_reg - root_reg);
        end
    end

    // Decision: class, step and upload
    logic [TIME_W-1:0]  last_step_reg, last_upload_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               armed_reg, armed_next;
    logic [TIME_W-1:0]  step_gap, upload_gap;
    logic               arm_hit, step_hit, upload_hit;
    logic [ACT_W-1:0]   act_next;

    assign step_gap   = now_reg - last_step_reg;
    assign upload_gap = now_reg - last_upload_reg;
    assign arm_hit    = (motion_reg > step_th_reg) && !armed_reg;
    assign step_hit   = arm_hit && (step_gap > TIME_W'(min_gap_reg));
    assign upload_hit = (upload_gap >= TIME_W'(upload_per_reg));
    assign count_next = step_hit ? count_reg + COUNT_W'(1) : count_reg;

    always_comb
    begin
        // release is checked after arming, so it wins on misordered thresholds
        armed_next = arm_hit ? 1'b1 : armed_reg;
        if (motion_reg < rel_th_reg)
        begin
            armed_next = 1'b0;
        end
        if (motion_reg < stat_lim_reg)
        begin
            act_next = ACT_STATIONARY;
        end
        else if (motion_reg < walk_lim_reg)
        begin
            act_next = ACT_WALKING;
        end
        else
        begin
            act_next = ACT_RUNNING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_step_reg   <= '0;
            last_upload_reg <= '0;
            count_reg       <= '0;
            armed_reg       <= 1'b0;
        end
        else if (cmd.dec_en)
        begin
            count_reg <= count_next;
            armed_reg <= armed_next;
            if (step_hit)
            begin
                last_step_reg <= now_reg;
            end
            if (upload_hit)
            begin
                last_upload_reg <= now_reg;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.dec_en)
        begin
            motion_level <= motion_reg;
            activity     <= act_next;
            step_total   <= count_next;
            step_seen    <= step_hit;
            upload_due   <= upload_hit;
        end
    end

endmodule

`default_nettype wire

/* src/accel_step_activity_detector_core.sv */
// ============================================================================
// accel_step_activity_detector_core: accelerometer step and activity detector
// Takes one three-axis sample with a millisecond timestamp per transaction and
// returns motion level, activity class, step count and upload flag.
// ============================================================================
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ------------------------------------
//  in       sink       in_valid / in_ready  accel_x, accel_y, accel_z, time_ms
//  out      source     out_valid/out_ready  motion_level, activity, step_total,
//                                           step_seen, upload_due
//  cfg      sink       cfg_we (no wait)     cfg_index, cfg_data
//
//  One sample passes from the accepting edge to a loaded result through the
//  sum of squares on the single shared multiplier, the bit-serial square
//  root (one root bit per cycle), the motion stage and the decision stage.
//  in_ready returns at the edge that loads the result, so the block takes
//  no new transaction until the result of the previous one is loaded.
//  A stalled output holds its result; the decision stage waits for it only if
//  a second result is ready before the first one is taken.
//  Reset restores all configuration defaults and clears the step counter,
//  the arm flag and both time marks.
// ============================================================================
`default_nettype none

module accel_step_activity_detector_core (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration writes
    input  wire logic                                   cfg_we,
    input  wire logic [asad_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [asad_pkg::CFG_DATA_W-1:0]        cfg_data,
    // sample channel
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [asad_pkg::AXIS_W-1:0]     accel_x,
    input  wire logic signed [asad_pkg::AXIS_W-1:0]     accel_y,
    input  wire logic signed [asad_pkg::AXIS_W-1:0]     accel_z,
    input  wire logic [asad_pkg::TIME_W-1:0]            time_ms,
    // result channel
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [asad_pkg::LEVEL_W-1:0]                motion_level,
    output logic [asad_pkg::ACT_W-1:0]                  activity,
    output logic [asad_pkg::COUNT_W-1:0]                step_total,
    output logic                                        step_seen,
    output logic                                        upload_due
);
    import asad_pkg::*;

    // command bundle from the sequencer to the datapath
    cmd_t cmd;

    // Sequence each transaction and own both handshakes
    asad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Compute magnitude, motion, class, steps and upload flag
    asad_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .time_ms      (time_ms),
        .motion_level (motion_level),
        .activity     (activity),
        .step_total   (step_total),
        .step_seen    (step_seen),
        .upload_due   (upload_due)
    );

endmodule

`default_nettype wire

/* tb/accel_step_activity_detector_core_tb.sv */
// ============================================================================
// accel_step_activity_detector_core_tb: self-checking bench for the detector
// Drives accelerometer samples through the valid/ready sample channel. A local
// model of magnitude, motion class, step and upload logic predicts each result
// transaction, and the results are compared field by field in order. The run
// covers boundary samples, extreme and misordered register settings, an
// unmapped register write and long randomized walking and running traffic.
// ============================================================================
`default_nettype none

module accel_step_activity_detector_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import asad_pkg::*;

    // Write to this index must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    // Cycles to hold after the last result before a register write or the end;
    // longer than the block's work on one sample, so this covers any work in flight
    localparam int SETTLE_CYCLES = 40;
    // Allow the slowest legal run several times over
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 225;

    typedef struct packed {
        logic [LEVEL_W-1:0] motion_level;
        logic [ACT_W-1:0]   activity;
        logic [COUNT_W-1:0] step_total;
        logic               step_seen;
        logic               upload_due;
    } result_t;

    typedef struct {
        logic [CFG_DATA_W-1:0] one_g;
        logic [CFG_DATA_W-1:0] stationary;
        logic [CFG_DATA_W-1:0] walking;
        logic [CFG_DATA_W-1:0] step_th;
        logic [CFG_DATA_W-1:0] release_th;
        logic [CFG_DATA_W-1:0] min_gap;
        logic [CFG_DATA_W-1:0] upload;
    } detector_regs_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index  = '0;
    logic [CFG_DATA_W-1:0]      cfg_data   = '0;
    logic                       in_valid   = 1'b0;
    logic                       in_ready;
    logic signed [AXIS_W-1:0]   accel_x    = '0;
    logic signed [AXIS_W-1:0]   accel_y    = '0;
    logic signed [AXIS_W-1:0]   accel_z    = '0;
    logic [TIME_W-1:0]          time_ms    = '0;
    logic                       out_valid;
    logic                       out_ready  = 1'b0;
    logic [LEVEL_W-1:0]         motion_level;
    logic [ACT_W-1:0]           activity;
    logic [COUNT_W-1:0]         step_total;
    logic                       step_seen;
    logic                       upload_due;

    // ------------------------------------------------------------------------
    // Shadow of the register file and of the step/upload state
    // ------------------------------------------------------------------------
    detector_regs_t     detector_regs = '{RST_ONE_G, RST_STATIONARY, RST_WALKING,
                                          RST_STEP_TH, RST_RELEASE_TH, RST_MIN_GAP,
                                          RST_UPLOAD};
    logic [TIME_W-1:0]  step_mark_ms   = '0;
    logic [COUNT_W-1:0] step_count     = '0;
    logic               above_arm      = 1'b0;
    logic [TIME_W-1:0]  upload_mark_ms = '0;

    result_t            pending_results[$];
    result_t            head_result;
    int                 err_count   = 0;
    int unsigned        cycle_count = 0;
    int                 burst_left  = 0;
    logic [TIME_W-1:0]  sample_ms   = '0;

    // Receiver stall pattern state
    int                 stall_mode   = 0;
    int                 stall_window = 0;
    logic [31:0]        stall_phase  = '0;

    accel_step_activity_detector_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .time_ms      (time_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .motion_level (motion_level),
        .activity     (activity),
        .step_total   (step_total),
        .step_seen    (step_seen),
        .upload_due   (upload_due)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Abort a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predict one result transaction and advance the shadow state.
    // Magnitude is the exact floor square root of the energy, found one root
    // bit at a time from the top; motion is its distance from one g.
    // ------------------------------------------------------------------------
    function automatic result_t predict_step(input logic signed [AXIS_W-1:0] ax,
                                             input logic signed [AXIS_W-1:0] ay,
                                             input logic signed [AXIS_W-1:0] az,
                                             input logic [TIME_W-1:0] stamp);
        longint             energy;
        logic [LEVEL_W-1:0] root;
        logic [LEVEL_W-1:0] trial;
        logic [TIME_W-1:0]  elapsed;
        result_t            r;

        energy = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
               + longint'(az) * longint'(az);
        root = '0;
        for (int b = LEVEL_W - 1; b >= 0; b--)
        begin
            trial = root | (LEVEL_W'(1) << b);
            if (longint'(trial) * longint'(trial) <= energy)
                root = trial;
        end

        r.motion_level = (root >= detector_regs.one_g) ? root - detector_regs.one_g
                                                       : detector_regs.one_g - root;

        // Test stationary first, then walking, even when the limits are misordered
        if (r.motion_level < detector_regs.stationary)
            r.activity = ACT_STATIONARY;
        else if (r.motion_level < detector_regs.walking)
            r.activity = ACT_WALKING;
        else
            r.activity = ACT_RUNNING;

        // Arm on a rising crossing; count only outside the minimum gap
        r.step_seen = 1'b0;
        if (r.motion_level > detector_regs.step_th && !above_arm)
        begin
            elapsed = stamp - step_mark_ms;
            if (elapsed > TIME_W'(detector_regs.min_gap))
            begin
                step_count   = step_count + 1;
                step_mark_ms = stamp;
                r.step_seen  = 1'b1;
            end
            above_arm = 1'b1;
        end
        // Release is applied after arming, so a misordered pair clears it at once
        if (r.motion_level < detector_regs.release_th)
            above_arm = 1'b0;

        elapsed = stamp - upload_mark_ms;
        r.upload_due = (elapsed >= TIME_W'(detector_regs.upload));
        if (r.upload_due)
            upload_mark_ms = stamp;

        r.step_total = step_count;
        return r;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: compare every accepted result against the oldest
    // prediction. Sample at the rising edge, before the block updates.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no prediction waiting: motion_level %0d",
                       motion_level);
                err_count++;
            end
            else
            begin
                head_result = pending_results.pop_front();
                check_field("motion_level", head_result.motion_level, motion_level);
                check_field("activity",     head_result.activity,     activity);
                check_field("step_total",   head_result.step_total,   step_total);
                check_field("step_seen",    head_result.step_seen,    step_seen);
                check_field("upload_due",   head_result.upload_due,   upload_due);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: switch between always ready, coin flip, mostly stalled and a
    // fixed 5-of-8 pattern, holding each mode for a random window
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_window == 0)
        begin
            stall_mode   = $urandom_range(0, 3);
            stall_window = $urandom_range(20, 300);
        end
        stall_window = stall_window - 1;
        stall_phase  = stall_phase + 1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 1);
            2:       out_ready <= ($urandom_range(0, 4) == 0);
            default: out_ready <= (stall_phase[2:0] < 3'd5);
        endcase
    end

    // ------------------------------------------------------------------------
    // Send one sample transaction. Between bursts, drop valid for a random
    // gap so that gaps land at every point of the block's work on a sample.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic signed [AXIS_W-1:0] ax,
                               input logic signed [AXIS_W-1:0] ay,
                               input logic signed [AXIS_W-1:0] az,
                               input logic [TIME_W-1:0] stamp);
        int gap;

        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(1, 30);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        burst_left = burst_left - 1;

        @(negedge clk);
        in_valid <= 1'b1;
        accel_x  <= ax;
        accel_y  <= ay;
        accel_z  <= az;
        time_ms  <= stamp;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_step(ax, ay, az, stamp));
    endtask

    // Hold the sender until every predicted result has been taken
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; only issued while the block is idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ONE_G:      detector_regs.one_g      = value;
            REG_STATIONARY: detector_regs.stationary = value;
            REG_WALKING:    detector_regs.walking    = value;
            REG_STEP_TH:    detector_regs.step_th    = value;
            REG_RELEASE_TH: detector_regs.release_th = value;
            REG_MIN_GAP:    detector_regs.min_gap    = value;
            REG_UPLOAD:     detector_regs.upload     = value;
            default:        ;
        endcase
    endtask

    task automatic write_all_registers(input logic [CFG_DATA_W-1:0] value);
        for (int i = REG_ONE_G; i <= REG_UPLOAD; i++)
            write_register(CFG_IDX_W'(i), value);
    endtask

    task automatic restore_defaults();
        write_register(REG_ONE_G,      RST_ONE_G);
        write_register(REG_STATIONARY, RST_STATIONARY);
        write_register(REG_WALKING,    RST_WALKING);
        write_register(REG_STEP_TH,    RST_STEP_TH);
        write_register(REG_RELEASE_TH, RST_RELEASE_TH);
        write_register(REG_MIN_GAP,    RST_MIN_GAP);
        write_register(REG_UPLOAD,     RST_UPLOAD);
    endtask

    task automatic load_random_setting();
        logic [CFG_DATA_W-1:0] step_th;

        step_th = CFG_DATA_W'($urandom_range(500, 6000));
        write_register(REG_ONE_G, ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom)
                                  : CFG_DATA_W'($urandom_range(14384, 18384)));
        write_register(REG_STATIONARY, CFG_DATA_W'($urandom_range(0, 3000)));
        write_register(REG_WALKING,    CFG_DATA_W'($urandom_range(0, 8000)));
        write_register(REG_STEP_TH,    step_th);
        // Mostly a sane hysteresis band, sometimes a misordered pair
        write_register(REG_RELEASE_TH, ($urandom_range(0, 9) == 0)
                                       ? CFG_DATA_W'($urandom_range(0, 9000))
                                       : CFG_DATA_W'($urandom_range(0, step_th)));
        write_register(REG_MIN_GAP,    CFG_DATA_W'($urandom_range(0, 400)));
        write_register(REG_UPLOAD,     ($urandom_range(0, 7) == 0) ? CFG_DATA_W'(0)
                                       : CFG_DATA_W'($urandom_range(1, 3000)));
    endtask

    // ------------------------------------------------------------------------
    // Walking/running traffic: motion aimed at the thresholds and class limits
    // around the current one-g level, plausible time steps around the minimum
    // gap, and some fully random samples and time jumps as noise
    // ------------------------------------------------------------------------
    task automatic send_activity(input int count);
        int                       target;
        int                       mag;
        int                       part;
        int                       axis;
        logic signed [AXIS_W-1:0] v [3];

        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                v[0] = AXIS_W'($urandom);
                v[1] = AXIS_W'($urandom);
                v[2] = AXIS_W'($urandom);
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: target = $urandom_range(0, int'(detector_regs.release_th));
                    1: target = int'(detector_regs.step_th) + int'($urandom_range(0, 6)) - 3;
                    2: target = int'(detector_regs.stationary) + int'($urandom_range(0, 2)) - 1;
                    3: target = int'(detector_regs.walking) + int'($urandom_range(0, 2)) - 1;
                    4: target = $urandom_range(0, 20000);
                    default: target = int'(detector_regs.step_th) + int'($urandom_range(0, 8000));
                endcase
                if (target < 0)
                    target = 0;
                mag = ($urandom_range(0, 1) == 1) ? int'(detector_regs.one_g) + target
                                                  : int'(detector_regs.one_g) - target;
                if (mag < 0)
                    mag = 0;
                if (mag > 56755)
                    mag = 56755;
                v[0] = '0;
                v[1] = '0;
                v[2] = '0;
                if (mag <= 32767)
                begin
                    // Gravity on one axis, occasionally a little cross-axis jitter
                    axis = $urandom_range(0, 2);
                    v[axis] = AXIS_W'(($urandom_range(0, 1) == 1) ? mag : -mag);
                    if ($urandom_range(0, 3) == 0)
                        v[(axis + 1) % 3] = AXIS_W'(int'($urandom_range(0, 300)) - 150);
                end
                else
                begin
                    // Spread a large magnitude evenly over all three axes
                    part = (mag * 37837) >>> 16;
                    if (part > 32767)
                        part = 32767;
                    for (int a = 0; a < 3; a++)
                        v[a] = AXIS_W'(($urandom_range(0, 1) == 1) ? part : -part);
                end
            end

            case ($urandom_range(0, 19))
                0:       sample_ms = $urandom;
                1:       sample_ms = sample_ms - $urandom_range(0, 500);
                2:       sample_ms = sample_ms + $urandom_range(0, 200000);
                default: sample_ms = sample_ms
                                   + $urandom_range(0, int'(detector_regs.min_gap) * 3 / 2 + 40);
            endcase

            send_sample(v[0], v[1], v[2], sample_ms);

            // Now and then let the pipe run dry mid-stream
            if ($urandom_range(0, 150) == 0)
                drain_pipeline();
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Boundary samples under the reset register values
    task automatic test_boundary_samples();
        send_sample(0, 0, 0, 0);                      // zero vector: arm inside the gap
        send_sample(0, 0, 16384, 5);                  // at rest: release
        send_sample(0, 0, -32768, 201);               // one ms past the gap: count
        send_sample(0, 0, 16384, 300);
        send_sample(0, 0, 18843, 401);                // just above threshold, gap not exceeded
        send_sample(0, 0, 17613, 450);                // motion at release: stay armed
        send_sample(0, 0, 17612, 460);                // just below release
        send_sample(0, 0, 18842, 700);                // motion at threshold: no arm
        send_sample(-32768, -32768, -32768, 999);     // largest magnitude
        send_sample(32767, 32767, 32767, 1000);       // upload period reached exactly
        send_sample(16384, 0, 0, 1001);
        send_sample(0, -17202, 0, 1100);              // stationary limit minus one
        send_sample(0, -17203, 0, 1110);              // stationary limit
        send_sample(0, 0, -20479, 1120);              // walking limit minus one
        send_sample(0, 0, -20480, 1130);              // walking limit
        send_sample(0, 16384, 0, 1140);
        send_sample(0, 0, 0, 32'hFFFF_FF00);          // far ahead in time
        send_sample(0, 0, 16384, 32'hFFFF_FFF0);
        send_sample(0, 0, -32768, 32'h0000_0010);     // timestamp wraps
        send_sample(0, 0, 16384, 32'h0000_0020);
        send_sample(0, 0, 0, 32'h0000_0005);          // time goes backwards
        send_sample(-1, 1, -1, 32'h0000_0006);
        send_sample(12345, -23456, 7, 32'h0000_0800);
        sample_ms = 32'h0000_0800;
    endtask

    // All registers at zero, then all at their maximum
    task automatic test_register_extremes();
        drain_pipeline();
        write_all_registers('0);
        send_sample(0, 0, 0, sample_ms);              // motion zero: never arms
        send_activity(8);
        drain_pipeline();
        write_all_registers('1);
        send_sample(0, 0, 0, sample_ms + 70000);      // motion at full scale
        send_activity(8);
    endtask

    // Thresholds and class limits in the wrong order
    task automatic test_misordered_registers();
        drain_pipeline();
        restore_defaults();
        write_register(REG_STEP_TH,    16'd1000);
        write_register(REG_RELEASE_TH, 16'd3000);
        write_register(REG_STATIONARY, 16'd2000);
        write_register(REG_WALKING,    16'd500);
        send_sample(0, 0, 18384, sample_ms + 500);    // arm and release together
        send_sample(0, 0, 18384, sample_ms + 900);    // rises again at once
        send_activity(10);
    endtask

    // A write past the last register must leave everything unchanged
    task automatic test_unmapped_register();
        drain_pipeline();
        restore_defaults();
        write_register(REG_UNMAPPED, '0);
        write_register(REG_UNMAPPED, '1);
        send_activity(8);
    endtask

    // Long random traffic, one register setting per phase
    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_pipeline();
            if (phase == 0)
                restore_defaults();
            else
                load_random_setting();
            send_activity(PHASE_ITEMS);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // Hold reset first, then release it away from the rising edge
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_boundary_samples();
        test_register_extremes();
        test_misordered_registers();
        test_unmapped_register();
        test_random_traffic();

        // Drop valid, wait out every prediction, then settle
        drain_pipeline();

        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
src/asad_pkg.sv
src/asad_ctrl.sv
src/asad_dp.sv
src/accel_step_activity_detector_core.sv
tb/accel_step_activity_detector_core_tb.sv
